[rtl/qtangent_encoder_unit_defines.svh]
// ---------------------------------------------------------------------------
// QTangent encoder: assertion macros
// Concurrent assertion forms used by the encoder's top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef QTANGENT_ENCODER_UNIT_DEFINES_SVH
`define QTANGENT_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define QTENC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is low.
`define QTENC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

[rtl/qtenc_pkg.sv]
// ---------------------------------------------------------------------------
// QTangent encoder package
// Types, widths and constants shared by the encoder pipeline.
// ---------------------------------------------------------------------------
package qtenc_pkg;

    localparam int IN_W         = 16;   // Q2.14 input code
    localparam int NEG_W        = IN_W + 1;   // normal after optional negation
    localparam int F_W          = IN_W + 3;   // diagonal combinations
    localparam int D_W          = NEG_W + 1;  // off-diagonal sums
    localparam int DMAG_W       = NEG_W;      // |D| <= 2^16
    localparam int S_W          = 17;         // largest combination + one
    localparam int Q214_ONE     = 16384;
    localparam int Q30_SHIFT    = 30;
    localparam int ROOT_W       = 24;
    localparam int SQ_STEPS     = ROOT_W;
    localparam int RAD_W        = 1 + S_W + Q30_SHIFT;
    localparam int SQ_REM_W     = ROOT_W + 3;
    localparam int DIV_REM_W    = ROOT_W + 1;
    localparam int DIV_STEPS    = 32;
    localparam int QMAG_W       = DIV_STEPS;
    localparam int DIV_PRESHIFT = 5;          // 37 - DIV_STEPS
    localparam int BIG_SHIFT    = QMAG_W - 1 - ROOT_W;
    localparam int QMAX         = 32767;
    localparam int QMAX_SHIFT   = 15;         // 32767 = 2^15 - 1
    localparam int CODE_W       = 15;
    localparam int OUT_W        = 16;
    localparam int PROD_W       = QMAG_W + QMAX_SHIFT;
    localparam int FRONT_STAGES = 5;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY      = FRONT_STAGES + SQ_STEPS + DIV_STEPS + BACK_STAGES;
    localparam logic [OUT_W-1:0] CODE_MIN = 16'h8000;

    // component slots
    localparam int IX = 0;
    localparam int IY = 1;
    localparam int IZ = 2;
    localparam int IW = 3;

    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

    typedef struct packed {
        logic signed [IN_W-1:0] tangent_x;
        logic signed [IN_W-1:0] tangent_y;
        logic signed [IN_W-1:0] tangent_z;
        logic signed [IN_W-1:0] binormal_x;
        logic signed [IN_W-1:0] binormal_y;
        logic signed [IN_W-1:0] binormal_z;
        logic signed [IN_W-1:0] normal_x;
        logic signed [IN_W-1:0] normal_y;
        logic signed [IN_W-1:0] normal_z;
    } frame_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_x;
        logic signed [OUT_W-1:0] quat_y;
        logic signed [OUT_W-1:0] quat_z;
        logic signed [OUT_W-1:0] quat_w;
    } quat_t;

    typedef struct packed {
        sel_t       sel;
        logic       reflected;
        logic [2:0] dneg;
    } meta_t;

    typedef struct packed {
        meta_t                   meta;
        logic [2:0][DMAG_W-1:0]  dmag;
    } side_t;

    typedef struct packed {
        logic           valid;
        logic [S_W-1:0] s;
        side_t          side;
    } rad_beat_t;

    typedef struct packed {
        logic              valid;
        logic [ROOT_W-1:0] r;
        side_t             side;
    } root_beat_t;

    typedef struct packed {
        logic                   valid;
        logic [ROOT_W-1:0]      r;
        meta_t                  meta;
        logic [2:0][QMAG_W-1:0] qmag;
    } quot_beat_t;

endpackage

[rtl/qtenc_front.sv]
// ---------------------------------------------------------------------------
// QTangent encoder front end
// Determinant, reflection fix-up, diagonal selection and off-diagonal terms.
// ---------------------------------------------------------------------------
module qtenc_front
    import qtenc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  frame_t    frame,
    output rad_beat_t rad
);

    logic [FRONT_STAGES-1:0] valid_reg;

    // stage 1: cofactor products
    frame_t                    f1_reg;
    logic signed [31:0]        p_next [6];
    logic signed [31:0]        p_reg  [6];
    // stage 2: row products
    frame_t                    f2_reg;
    logic signed [32:0]        c_next [3];
    logic signed [48:0]        m_next [3];
    logic signed [48:0]        m_reg  [3];
    // stage 3: determinant sign
    frame_t                    f3_reg;
    logic signed [50:0]        det_next;
    logic                      refl_next;
    logic                      refl3_reg;
    // stage 4: fixed-up normal and diagonal sums
    logic signed [NEG_W-1:0]   nx_next, ny_next, nz_next;
    logic signed [F_W-1:0]     fw_next, fx_next, fy_next, fz_next;
    logic signed [IN_W-1:0]    tx4_reg, ty4_reg, tz4_reg, bx4_reg, by4_reg, bz4_reg;
    logic signed [NEG_W-1:0]   nx4_reg, ny4_reg, nz4_reg;
    logic signed [F_W-1:0]     fw4_reg, fx4_reg, fy4_reg, fz4_reg;
    logic                      refl4_reg;
    // stage 5: selection
    logic signed [F_W-1:0]     big;
    logic signed [F_W-1:0]     s_wide;
    sel_t                      sel;
    logic signed [D_W-1:0]     a_bzny, a_nxtz, a_tybx, p_tybx, p_nxtz, p_bzny;
    logic signed [D_W-1:0]     d [3];
    logic [S_W-1:0]            s_next, s_reg;
    side_t                     side_next, side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    // stage 1
    always_comb
    begin
        p_next[0] = 32'(frame.binormal_y) * 32'(frame.normal_z);
        p_next[1] = 32'(frame.binormal_z) * 32'(frame.normal_y);
        p_next[2] = 32'(frame.binormal_x) * 32'(frame.normal_z);
        p_next[3] = 32'(frame.binormal_z) * 32'(frame.normal_x);
        p_next[4] = 32'(frame.binormal_x) * 32'(frame.normal_y);
        p_next[5] = 32'(frame.binormal_y) * 32'(frame.normal_x);
    end

    // stage 2
    always_comb
    begin
        c_next[0] = 33'(p_reg[0]) - 33'(p_reg[1]);
        c_next[1] = 33'(p_reg[2]) - 33'(p_reg[3]);
        c_next[2] = 33'(p_reg[4]) - 33'(p_reg[5]);
        m_next[0] = 49'(f1_reg.tangent_x) * 49'(c_next[0]);
        m_next[1] = 49'(f1_reg.tangent_y) * 49'(c_next[1]);
        m_next[2] = 49'(f1_reg.tangent_z) * 49'(c_next[2]);
    end

    // stage 3: zero determinant counts as reflected
    always_comb
    begin
        det_next  = 51'(m_reg[0]) - 51'(m_reg[1]) + 51'(m_reg[2]);
        refl_next = !(det_next > 51'sd0);
    end

    // stage 4
    always_comb
    begin
        nx_next = refl3_reg ? -NEG_W'(f3_reg.normal_x) : NEG_W'(f3_reg.normal_x);
        ny_next = refl3_reg ? -NEG_W'(f3_reg.normal_y) : NEG_W'(f3_reg.normal_y);
        nz_next = refl3_reg ? -NEG_W'(f3_reg.normal_z) : NEG_W'(f3_reg.normal_z);
        fw_next = F_W'(f3_reg.tangent_x) + F_W'(f3_reg.binormal_y) + F_W'(nz_next);
        fx_next = F_W'(f3_reg.tangent_x) - F_W'(f3_reg.binormal_y) - F_W'(nz_next);
        fy_next = F_W'(f3_reg.binormal_y) - F_W'(f3_reg.tangent_x) - F_W'(nz_next);
        fz_next = F_W'(nz_next) - F_W'(f3_reg.tangent_x) - F_W'(f3_reg.binormal_y);
    end

    // stage 5: ties go to the earlier of w, x, y, z
    always_comb
    begin
        big = fw4_reg;
        sel = SEL_W;
        if (fx4_reg > big)
        begin
            big = fx4_reg;
            sel = SEL_X;
        end
        if (fy4_reg > big)
        begin
            big = fy4_reg;
            sel = SEL_Y;
        end
        if (fz4_reg > big)
        begin
            big = fz4_reg;
            sel = SEL_Z;
        end
        s_wide = big + F_W'(Q214_ONE);
        s_next = s_wide[S_W-1:0];

        a_bzny = D_W'(bz4_reg) - D_W'(ny4_reg);
        a_nxtz = D_W'(nx4_reg) - D_W'(tz4_reg);
        a_tybx = D_W'(ty4_reg) - D_W'(bx4_reg);
        p_tybx = D_W'(ty4_reg) + D_W'(bx4_reg);
        p_nxtz = D_W'(nx4_reg) + D_W'(tz4_reg);
        p_bzny = D_W'(bz4_reg) + D_W'(ny4_reg);

        case (sel)
            SEL_W:
            begin
                d[0] = a_bzny;
                d[1] = a_nxtz;
                d[2] = a_tybx;
            end
            SEL_X:
            begin
                d[0] = a_bzny;
                d[1] = p_tybx;
                d[2] = p_nxtz;
            end
            SEL_Y:
            begin
                d[0] = a_nxtz;
                d[1] = p_tybx;
                d[2] = p_bzny;
            end
            default:
            begin
                d[0] = a_tybx;
                d[1] = p_nxtz;
                d[2] = p_bzny;
            end
        endcase

        side_next.meta.sel       = sel;
        side_next.meta.reflected = refl4_reg;
        for (int i = 0; i < 3; i++)
        begin
            side_next.meta.dneg[i] = d[i][D_W-1];
            side_next.dmag[i]      = d[i][D_W-1] ? DMAG_W'(-d[i]) : DMAG_W'(d[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        f1_reg    <= frame;
        p_reg     <= p_next;
        f2_reg    <= f1_reg;
        m_reg     <= m_next;
        f3_reg    <= f2_reg;
        refl3_reg <= refl_next;
        tx4_reg   <= f3_reg.tangent_x;
        ty4_reg   <= f3_reg.tangent_y;
        tz4_reg   <= f3_reg.tangent_z;
        bx4_reg   <= f3_reg.binormal_x;
        by4_reg   <= f3_reg.binormal_y;
        bz4_reg   <= f3_reg.binormal_z;
        nx4_reg   <= nx_next;
        ny4_reg   <= ny_next;
        nz4_reg   <= nz_next;
        fw4_reg   <= fw_next;
        fx4_reg   <= fx_next;
        fy4_reg   <= fy_next;
        fz4_reg   <= fz_next;
        refl4_reg <= refl3_reg;
        s_reg     <= s_next;
        side_reg  <= side_next;
    end

    // f2 passes the whole frame on to f3 for use in stage 4
    assign rad.valid = valid_reg[FRONT_STAGES-1];
    assign rad.s     = s_reg;
    assign rad.side  = side_reg;

endmodule

[rtl/qtenc_sqrt.sv]
// ---------------------------------------------------------------------------
// QTangent encoder square root
// Pipelined restoring square root, one root bit per stage.
// ---------------------------------------------------------------------------
module qtenc_sqrt
    import qtenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rad_beat_t  rad,
    output root_beat_t root
);

    logic [SQ_STEPS-1:0] valid_reg;
    logic [SQ_REM_W-1:0] rem_reg  [SQ_STEPS];
    logic [ROOT_W-1:0]   root_reg [SQ_STEPS];
    logic [S_W-1:0]      s_reg    [SQ_STEPS];
    side_t               side_reg [SQ_STEPS];

    genvar k;
    for (k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam int PAIR = SQ_STEPS - 1 - k;
        logic                v_in;
        logic [SQ_REM_W-1:0] rem_in, cur, trial, rem_next;
        logic [ROOT_W-1:0]   root_in, root_next;
        logic [S_W-1:0]      s_in;
        side_t               side_in;
        logic [RAD_W-1:0]    rad_bits;

        if (k == 0)
        begin : g_first
            assign v_in    = rad.valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = rad.s;
            assign side_in = rad.side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            rad_bits = {1'b0, s_in, {Q30_SHIFT{1'b0}}};
            cur      = {rem_in[SQ_REM_W-3:0], rad_bits[2*PAIR+1 -: 2]};
            trial    = SQ_REM_W'({root_in, 2'b01});
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            s_reg[k]    <= s_in;
            side_reg[k] <= side_in;
        end
    end

    assign root.valid = valid_reg[SQ_STEPS-1];
    assign root.r     = root_reg[SQ_STEPS-1];
    assign root.side  = side_reg[SQ_STEPS-1];

endmodule

[rtl/qtenc_div.sv]
// ---------------------------------------------------------------------------
// QTangent encoder divider
// Three-lane pipelined restoring divider: |D| * 2^37 / r, one bit per stage.
// ---------------------------------------------------------------------------
module qtenc_div
    import qtenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  root_beat_t root,
    output quot_beat_t quot
);

    logic [DIV_STEPS-1:0]         valid_reg;
    logic [2:0][DIV_REM_W-1:0]    rem_reg  [DIV_STEPS];
    logic [2:0][QMAG_W-1:0]       q_reg    [DIV_STEPS];
    logic [ROOT_W-1:0]            r_reg    [DIV_STEPS];
    meta_t                        meta_reg [DIV_STEPS];

    genvar k;
    for (k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic                      v_in;
        logic [2:0][DIV_REM_W-1:0] rem_in, rem_next;
        logic [2:0][QMAG_W-1:0]    q_in, q_next;
        logic [ROOT_W-1:0]         r_in;
        meta_t                     meta_in;
        logic [DIV_REM_W-1:0]      cur [3];
        logic [DIV_REM_W-1:0]      dv;

        if (k == 0)
        begin : g_first
            // |D| < 2^17 so |D| << 5 is already below r
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_in[l] = DIV_REM_W'({root.side.dmag[l], {DIV_PRESHIFT{1'b0}}});
            end
            assign v_in    = root.valid;
            assign q_in    = '0;
            assign r_in    = root.r;
            assign meta_in = root.side.meta;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign r_in    = r_reg[k-1];
            assign meta_in = meta_reg[k-1];
        end

        always_comb
        begin
            dv = DIV_REM_W'(r_in);
            for (int l = 0; l < 3; l++)
            begin
                cur[l] = {rem_in[l][DIV_REM_W-2:0], 1'b0};
                if (cur[l] >= dv)
                begin
                    rem_next[l] = cur[l] - dv;
                    q_next[l]   = {q_in[l][QMAG_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = cur[l];
                    q_next[l]   = {q_in[l][QMAG_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            q_reg[k]    <= q_next;
            r_reg[k]    <= r_in;
            meta_reg[k] <= meta_in;
        end
    end

    assign quot.valid = valid_reg[DIV_STEPS-1];
    assign quot.r     = r_reg[DIV_STEPS-1];
    assign quot.meta  = meta_reg[DIV_STEPS-1];
    assign quot.qmag  = q_reg[DIV_STEPS-1];

endmodule

[rtl/qtenc_back.sv]
// ---------------------------------------------------------------------------
// QTangent encoder back end
// Component placement, small-w clamp, quantisation and reflection sign.
// ---------------------------------------------------------------------------
module qtenc_back
    import qtenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  quot_beat_t quot,
    output logic       done,
    output quat_t      quat
);

    logic [BACK_STAGES-1:0]  valid_reg;

    // stage 1
    logic [QMAG_W-1:0]       bigm;
    logic [3:0][QMAG_W-1:0]  mag;
    logic [3:0]              neg;
    logic [PROD_W-1:0]       wprod;
    logic                    clamp_next, wpos_next, flip_next;
    logic [QMAG_W:0]         ceil_q [3];
    logic [3:0][QMAG_W-1:0]  mag_next, mag1_reg;
    logic [3:0]              neg1_reg;
    logic                    clamp1_reg, wpos1_reg, flip1_reg;
    // stage 2
    logic [3:0][CODE_W-1:0]  c_next, c2_reg;
    logic [3:0]              nf_next, nf2_reg;
    // stage 3
    logic [3:0][OUT_W-1:0]   code_next, code3_reg;

    function automatic logic [CODE_W-1:0] quant(input logic [QMAG_W-1:0] m);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-Q30_SHIFT-1:0] sh;
        begin
            prod = PROD_W'({m, {QMAX_SHIFT{1'b0}}}) - PROD_W'(m);
            sh   = prod[PROD_W-1:Q30_SHIFT];
            quant = (sh > (PROD_W-Q30_SHIFT)'(QMAX)) ? CODE_W'(QMAX) : sh[CODE_W-1:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[BACK_STAGES-2:0], quot.valid};
        end
    end

    // stage 1: the largest component is r << 7, always positive
    always_comb
    begin
        bigm = QMAG_W'({quot.r, {BIG_SHIFT{1'b0}}});
        case (quot.meta.sel)
            SEL_W:
            begin
                mag[IW] = bigm;         neg[IW] = 1'b0;
                mag[IX] = quot.qmag[0]; neg[IX] = quot.meta.dneg[0];
                mag[IY] = quot.qmag[1]; neg[IY] = quot.meta.dneg[1];
                mag[IZ] = quot.qmag[2]; neg[IZ] = quot.meta.dneg[2];
            end
            SEL_X:
            begin
                mag[IX] = bigm;         neg[IX] = 1'b0;
                mag[IW] = quot.qmag[0]; neg[IW] = quot.meta.dneg[0];
                mag[IY] = quot.qmag[1]; neg[IY] = quot.meta.dneg[1];
                mag[IZ] = quot.qmag[2]; neg[IZ] = quot.meta.dneg[2];
            end
            SEL_Y:
            begin
                mag[IY] = bigm;         neg[IY] = 1'b0;
                mag[IW] = quot.qmag[0]; neg[IW] = quot.meta.dneg[0];
                mag[IX] = quot.qmag[1]; neg[IX] = quot.meta.dneg[1];
                mag[IZ] = quot.qmag[2]; neg[IZ] = quot.meta.dneg[2];
            end
            default:
            begin
                mag[IZ] = bigm;         neg[IZ] = 1'b0;
                mag[IW] = quot.qmag[0]; neg[IW] = quot.meta.dneg[0];
                mag[IX] = quot.qmag[1]; neg[IX] = quot.meta.dneg[1];
                mag[IY] = quot.qmag[2]; neg[IY] = quot.meta.dneg[2];
            end
        endcase

        wprod      = PROD_W'({mag[IW], {QMAX_SHIFT{1'b0}}}) - PROD_W'(mag[IW]);
        clamp_next = wprod < (PROD_W'(1) << Q30_SHIFT);
        wpos_next  = !neg[IW] && (mag[IW] != '0);
        flip_next  = (wpos_next == quot.meta.reflected);

        // clamped: xyz * (2^30 - 1) / 2^30, truncated, i.e. m - ceil(m / 2^30)
        mag_next[IW] = mag[IW];
        for (int i = 0; i < 3; i++)
        begin
            ceil_q[i] = ((QMAG_W+1)'(mag[i]) + (QMAG_W+1)'((64'd1 << Q30_SHIFT) - 64'd1))
                        >> Q30_SHIFT;
            mag_next[i] = clamp_next ? (mag[i] - ceil_q[i][QMAG_W-1:0]) : mag[i];
        end
    end

    // stage 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_next[i]  = quant(mag1_reg[i]);
            nf_next[i] = neg1_reg[i] ^ flip1_reg;
        end
        c_next[IW]  = clamp1_reg ? CODE_W'(1) : quant(mag1_reg[IW]);
        nf_next[IW] = (clamp1_reg ? !wpos1_reg : neg1_reg[IW]) ^ flip1_reg;
    end

    // stage 3
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            code_next[i] = nf2_reg[i] ? -OUT_W'(c2_reg[i]) : OUT_W'(c2_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        mag1_reg   <= mag_next;
        neg1_reg   <= neg;
        clamp1_reg <= clamp_next;
        wpos1_reg  <= wpos_next;
        flip1_reg  <= flip_next;
        c2_reg     <= c_next;
        nf2_reg    <= nf_next;
        code3_reg  <= code_next;
    end

    assign done        = valid_reg[BACK_STAGES-1];
    assign quat.quat_x = code3_reg[IX];
    assign quat.quat_y = code3_reg[IY];
    assign quat.quat_z = code3_reg[IZ];
    assign quat.quat_w = code3_reg[IW];

endmodule

[rtl/qtangent_encoder_unit.sv]
// ---------------------------------------------------------------------------
// QTangent encoder unit
// Packs a T/B/N tangent frame into a 16-bit-per-component QTangent.
// ---------------------------------------------------------------------------
// Usage:
//   Input beat: drive frame (nine signed Q2.14 codes) and raise start; the
//   beat is taken at any rising edge where start is high and busy is low.
//   busy is held low: the pipeline takes one frame every cycle.
//   Output beat: done is high for exactly one cycle with the four codes on
//   quat; the receiver has no way to hold results off and none is needed.
//   Pipeline: from the accepting edge to the edge that samples done lie
//   5 front-end stages, 24 square-root stages at one root bit each,
//   32 divider stages at one quotient bit each and 3 back-end stages.
//   Throughput: one beat per cycle, set by the fully pipelined root and
//   divider stages.
//   Reset: rst_n low clears every stage valid bit at once; frames in flight
//   are dropped and no done pulse follows them.
//   Results leave in the order that frames arrive.
// ---------------------------------------------------------------------------
`include "qtangent_encoder_unit_defines.svh"

module qtangent_encoder_unit
    import qtenc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  frame_t frame,
    output logic   done,
    output quat_t  quat
);

    rad_beat_t  rad;
    root_beat_t root;
    quot_beat_t quot;

    // every stage advances each cycle, so nothing ever back-pressures
    assign busy = 1'b0;

    // determinant, reflection and largest-diagonal choice
    qtenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .frame    (frame),
        .rad      (rad)
    );

    // r = floor(sqrt(S * 2^30))
    qtenc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .rad   (rad),
        .root  (root)
    );

    // off-diagonal components: |D| * 2^37 / r
    qtenc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .root  (root),
        .quot  (quot)
    );

    // clamp, quantise, force w sign
    qtenc_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .quot  (quot),
        .done  (done),
        .quat  (quat)
    );

    // every accepted frame comes out after the fixed pipeline depth
    `QTENC_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, LATENCY, done, "frame lost in pipeline")
    // w is clamped away from zero, so its code is never zero
    `QTENC_ASSERT_IMPL(a_w_nonzero, clk, rst_n, done, quat.quat_w != '0, "w code is zero")
    // codes saturate symmetrically
    `QTENC_ASSERT_IMPL(a_code_range, clk, rst_n, done, (quat.quat_x != CODE_MIN) && (quat.quat_y != CODE_MIN) && (quat.quat_z != CODE_MIN) && (quat.quat_w != CODE_MIN), "code out of range")

endmodule
